// ===== rtl/tcse_pkg.sv =====
package tcse_pkg;

    localparam int DEF_COLS = 80;
    localparam int DEF_ROWS = 25;

    localparam logic [7:0] CH_NL = 8'd10;
    localparam logic [7:0] CH_CR = 8'd13;
    localparam logic [7:0] CH_SP = 8'd32;

    localparam logic [2:0] MD_PUT_CUR  = 3'd0;
    localparam logic [2:0] MD_PUT_CELL = 3'd1;
    localparam logic [2:0] MD_MOVE     = 3'd2;
    localparam logic [2:0] MD_CLR_REG  = 3'd3;
    localparam logic [2:0] MD_CLR_SCR  = 3'd4;
    localparam logic [2:0] MD_SCROLL   = 3'd5;
    localparam logic [2:0] MD_READ     = 3'd6;
    localparam logic [2:0] MD_UNUSED   = 3'd7;

    localparam logic [1:0] REG_LEFT   = 2'd0;
    localparam logic [1:0] REG_TOP    = 2'd1;
    localparam logic [1:0] REG_RIGHT  = 2'd2;
    localparam logic [1:0] REG_BOTTOM = 2'd3;

    typedef logic [2:0] t_su;
    localparam t_su SU_NONE    = 3'd0;
    localparam t_su SU_REGION  = 3'd1;
    localparam t_su SU_SCREEN  = 3'd2;
    localparam t_su SU_COPY    = 3'd3;
    localparam t_su SU_TAIL    = 3'd4;
    localparam t_su SU_NL_CUR  = 3'd5;
    localparam t_su SU_NL_CELL = 3'd6;

    typedef logic [1:0] t_wsrc;
    localparam t_wsrc WS_SPACE = 2'd0;
    localparam t_wsrc WS_CUR   = 2'd1;
    localparam t_wsrc WS_CELL  = 2'd2;
    localparam t_wsrc WS_COPY  = 2'd3;

    typedef logic [2:0] t_cu;
    localparam t_cu CU_NONE = 3'd0;
    localparam t_cu CU_HOME = 3'd1;
    localparam t_cu CU_ROWB = 3'd2;
    localparam t_cu CU_NL   = 3'd3;
    localparam t_cu CU_CR   = 3'd4;
    localparam t_cu CU_ADV  = 3'd5;
    localparam t_cu CU_MOVE = 3'd6;

    typedef struct packed {
        logic  load_item;
        logic  latch_pend;
        t_su   su;
        logic  step;
        logic  we;
        t_wsrc wsrc;
        logic  rd_copy;
        logic  rd_cell;
        logic  cell_cap;
        t_cu   cu;
        logic  load_out;
    } t_cmd;

    typedef struct packed {
        logic [2:0] mode;
        logic       is_nl;
        logic       is_cr;
        logic       pending;
        logic       whole;
        logic       zero_lines;
        logic       nl_empty;
        logic       cell_ok;
        logic       last;
    } t_stat;

endpackage

// ===== rtl/tcse_ctrl.sv =====
module tcse_ctrl
    import tcse_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    output logic  o_out_valid,
    input  logic  i_out_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    localparam logic [3:0] S_INIT    = 4'd0;
    localparam logic [3:0] S_IDLE    = 4'd1;
    localparam logic [3:0] S_DISP    = 4'd2;
    localparam logic [3:0] S_SCR     = 4'd3;
    localparam logic [3:0] S_FILL    = 4'd4;
    localparam logic [3:0] S_CRD     = 4'd5;
    localparam logic [3:0] S_CWR     = 4'd6;
    localparam logic [3:0] S_SCRDONE = 4'd7;
    localparam logic [3:0] S_PUTC    = 4'd8;
    localparam logic [3:0] S_NLDONE  = 4'd9;
    localparam logic [3:0] S_RD      = 4'd10;
    localparam logic [3:0] S_RDW     = 4'd11;
    localparam logic [3:0] S_DONE    = 4'd12;

    logic [3:0] r_state, n_state;
    logic [3:0] r_ret, n_ret;
    logic       r_from_cur, n_from_cur;
    logic       r_ov, n_ov;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_ov;

    always_comb begin
        n_state    = r_state;
        n_ret      = r_ret;
        n_from_cur = r_from_cur;
        n_ov       = r_ov;
        o_cmd      = '0;
        if (r_ov && i_out_ready) begin
            n_ov = 1'b0;
        end
        case (r_state)
            S_INIT: begin
                o_cmd.su = SU_SCREEN;
                n_ret    = S_IDLE;
                n_state  = S_FILL;
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_item = 1'b1;
                    n_state         = S_DISP;
                end
            end
            S_DISP: begin
                case (i_stat.mode)
                    MD_PUT_CUR: begin
                        if (i_stat.pending) begin
                            o_cmd.latch_pend = 1'b1;
                            n_from_cur       = 1'b1;
                            n_state          = S_SCR;
                        end else begin
                            n_state = S_PUTC;
                        end
                    end
                    MD_PUT_CELL: begin
                        if (i_stat.is_nl) begin
                            if (i_stat.nl_empty) begin
                                n_state = S_DONE;
                            end else begin
                                o_cmd.su = SU_NL_CELL;
                                n_ret    = S_DONE;
                                n_state  = S_FILL;
                            end
                        end else begin
                            o_cmd.we   = i_stat.cell_ok;
                            o_cmd.wsrc = WS_CELL;
                            n_state    = S_DONE;
                        end
                    end
                    MD_MOVE: begin
                        o_cmd.cu = CU_MOVE;
                        n_state  = S_DONE;
                    end
                    MD_CLR_REG: begin
                        o_cmd.su = SU_REGION;
                        n_ret    = S_DONE;
                        n_state  = S_FILL;
                    end
                    MD_CLR_SCR: begin
                        o_cmd.su = SU_SCREEN;
                        n_ret    = S_DONE;
                        n_state  = S_FILL;
                    end
                    MD_SCROLL: begin
                        n_from_cur = 1'b0;
                        n_state    = S_SCR;
                    end
                    MD_READ: begin
                        n_state = i_stat.cell_ok ? S_RD : S_DONE;
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end
            S_SCR: begin
                if (i_stat.whole) begin
                    o_cmd.cu = CU_HOME;
                    o_cmd.su = SU_REGION;
                    n_ret    = S_SCRDONE;
                    n_state  = S_FILL;
                end else if (i_stat.zero_lines) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.su = SU_COPY;
                    n_state  = S_CRD;
                end
            end
            S_FILL: begin
                o_cmd.we   = 1'b1;
                o_cmd.wsrc = WS_SPACE;
                o_cmd.step = 1'b1;
                if (i_stat.last) begin
                    n_state = r_ret;
                end
            end
            S_CRD: begin
                o_cmd.rd_copy = 1'b1;
                n_state       = S_CWR;
            end
            S_CWR: begin
                o_cmd.we   = 1'b1;
                o_cmd.wsrc = WS_COPY;
                o_cmd.step = 1'b1;
                if (i_stat.last) begin
                    o_cmd.su = SU_TAIL;
                    n_ret    = S_SCRDONE;
                    n_state  = S_FILL;
                end else begin
                    n_state = S_CRD;
                end
            end
            S_SCRDONE: begin
                if (r_from_cur) begin
                    o_cmd.cu = CU_ROWB;
                    n_state  = S_PUTC;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_PUTC: begin
                if (i_stat.is_nl) begin
                    o_cmd.su = SU_NL_CUR;
                    n_ret    = S_NLDONE;
                    n_state  = S_FILL;
                end else if (i_stat.is_cr) begin
                    o_cmd.cu = CU_CR;
                    n_state  = S_DONE;
                end else begin
                    o_cmd.we   = 1'b1;
                    o_cmd.wsrc = WS_CUR;
                    o_cmd.cu   = CU_ADV;
                    n_state    = S_DONE;
                end
            end
            S_NLDONE: begin
                o_cmd.cu = CU_NL;
                n_state  = S_DONE;
            end
            S_RD: begin
                o_cmd.rd_cell = 1'b1;
                n_state       = S_RDW;
            end
            S_RDW: begin
                o_cmd.cell_cap = 1'b1;
                n_state        = S_DONE;
            end
            S_DONE: begin
                if (!r_ov || i_out_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_ov           = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_INIT;
            r_ret      <= S_IDLE;
            r_from_cur <= 1'b0;
            r_ov       <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_ret      <= n_ret;
            r_from_cur <= n_from_cur;
            r_ov       <= n_ov;
        end
    end

endmodule

// ===== rtl/tcse_dp.sv =====
module tcse_dp
    import tcse_pkg::*;
#(
    parameter int COLS = DEF_COLS,
    parameter int ROWS = DEF_ROWS
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_index,
    input  logic [6:0] i_cfg_data,
    input  logic [2:0] i_mode,
    input  logic [7:0] i_char_code,
    input  logic [7:0] i_col,
    input  logic [7:0] i_row,
    input  logic [7:0] i_scroll_lines,
    output logic [7:0] o_cell_char,
    output logic [6:0] o_cursor_col,
    output logic [4:0] o_cursor_row,
    input  t_cmd       i_cmd,
    output t_stat      o_stat
);

    localparam int AW = $clog2(COLS * ROWS);
    localparam logic [6:0] LMAX = 7'(COLS - 1);
    localparam logic [4:0] TMAX = 5'(ROWS - 1);

    logic [7:0] mem [COLS*ROWS];
    logic [7:0] r_rdata;

    logic [6:0] r_left, r_right, n_left, n_right;
    logic [4:0] r_top, r_bottom, n_top, n_bottom;
    logic [6:0] el, er;
    logic [4:0] et, eb;

    logic [6:0] r_cur_col;
    logic [5:0] r_cur_row;

    logic [2:0] r_mode;
    logic [7:0] r_char, r_col, r_row, r_lines, r_cell;

    logic [6:0] r_x, r_x0, r_x1, sx0, sx1;
    logic [4:0] r_y, r_y1, sy0, sy1;

    logic [6:0] nl_lim;
    logic       nl_none;
    logic       cell_ok;
    logic [8:0] mv_col, mv_row;

    logic [AW-1:0] a_sweep, a_copy, a_cell, a_cur, wr_addr, rd_addr;
    logic [7:0]    wr_data;
    logic [4:0]    copy_y;

    always_comb begin
        n_left   = r_left;
        n_top    = r_top;
        n_right  = r_right;
        n_bottom = r_bottom;
        if (i_cfg_we) begin
            case (i_cfg_index)
                REG_LEFT:   n_left   = i_cfg_data;
                REG_TOP:    n_top    = i_cfg_data[4:0];
                REG_RIGHT:  n_right  = i_cfg_data;
                REG_BOTTOM: n_bottom = i_cfg_data[4:0];
                default:    n_left   = r_left;
            endcase
        end
        el = (n_left > LMAX) ? LMAX : n_left;
        et = (n_top > TMAX) ? TMAX : n_top;
        er = (n_right < el) ? el : ((n_right > LMAX) ? LMAX : n_right);
        eb = (n_bottom < et) ? et : ((n_bottom > TMAX) ? TMAX : n_bottom);
    end

    always_comb begin
        nl_none = 1'b0;
        if (r_col > {1'b0, er}) begin
            nl_lim = LMAX;
        end else if (r_col >= {1'b0, el}) begin
            nl_lim = er;
        end else if (el == 7'd0) begin
            nl_lim  = 7'd0;
            nl_none = 1'b1;
        end else begin
            nl_lim = el - 7'd1;
        end
    end

    assign cell_ok = (9'(r_col) < 9'(COLS)) && (9'(r_row) < 9'(ROWS));
    assign mv_col  = 9'(r_col) + 9'(el);
    assign mv_row  = 9'(r_row) + 9'(et);

    assign o_stat.mode       = r_mode;
    assign o_stat.is_nl      = (r_char == CH_NL);
    assign o_stat.is_cr      = (r_char == CH_CR);
    assign o_stat.pending    = (r_cur_row > {1'b0, eb});
    assign o_stat.whole      = (r_lines > 8'(eb - et));
    assign o_stat.zero_lines = (r_lines == 8'd0);
    assign o_stat.nl_empty   = nl_none || (r_col > {1'b0, nl_lim}) || !cell_ok;
    assign o_stat.cell_ok    = cell_ok;
    assign o_stat.last       = (r_x == r_x1) && (r_y == r_y1);

    always_comb begin
        sx0 = el;
        sx1 = er;
        sy0 = et;
        sy1 = eb;
        case (i_cmd.su)
            SU_SCREEN: begin
                sx0 = 7'd0;
                sx1 = LMAX;
                sy0 = 5'd0;
                sy1 = TMAX;
            end
            SU_COPY: begin
                sy1 = eb - r_lines[4:0];
            end
            SU_TAIL: begin
                sy0 = eb - r_lines[4:0] + 5'd1;
            end
            SU_NL_CUR: begin
                sx0 = r_cur_col;
                sy0 = r_cur_row[4:0];
                sy1 = r_cur_row[4:0];
            end
            SU_NL_CELL: begin
                sx0 = r_col[6:0];
                sx1 = nl_lim;
                sy0 = r_row[4:0];
                sy1 = r_row[4:0];
            end
            default: begin
                sx0 = el;
            end
        endcase
    end

    assign copy_y  = r_y + r_lines[4:0];
    assign a_sweep = AW'(r_y) * AW'(COLS) + AW'(r_x);
    assign a_copy  = AW'(copy_y) * AW'(COLS) + AW'(r_x);
    assign a_cell  = AW'(r_row[4:0]) * AW'(COLS) + AW'(r_col[6:0]);
    assign a_cur   = AW'(r_cur_row[4:0]) * AW'(COLS) + AW'(r_cur_col);
    assign rd_addr = i_cmd.rd_copy ? a_copy : a_cell;

    always_comb begin
        case (i_cmd.wsrc)
            WS_SPACE: begin
                wr_addr = a_sweep;
                wr_data = CH_SP;
            end
            WS_CUR: begin
                wr_addr = a_cur;
                wr_data = r_char;
            end
            WS_CELL: begin
                wr_addr = a_cell;
                wr_data = r_char;
            end
            default: begin
                wr_addr = a_sweep;
                wr_data = r_rdata;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.we) begin
            mem[wr_addr] <= wr_data;
        end
        if (i_cmd.rd_copy || i_cmd.rd_cell) begin
            r_rdata <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.su != SU_NONE) begin
            r_x  <= sx0;
            r_x0 <= sx0;
            r_x1 <= sx1;
            r_y  <= sy0;
            r_y1 <= sy1;
        end else if (i_cmd.step) begin
            if (r_x == r_x1) begin
                r_x <= r_x0;
                r_y <= r_y + 5'd1;
            end else begin
                r_x <= r_x + 7'd1;
            end
        end
        if (i_cmd.load_item) begin
            r_mode  <= i_mode;
            r_char  <= i_char_code;
            r_col   <= i_col;
            r_row   <= i_row;
            r_lines <= i_scroll_lines;
            r_cell  <= 8'd0;
        end else begin
            if (i_cmd.latch_pend) begin
                r_lines <= 8'(r_cur_row - {1'b0, eb});
            end
            if (i_cmd.cell_cap) begin
                r_cell <= r_rdata;
            end
        end
        if (i_cmd.load_out) begin
            o_cell_char  <= r_cell;
            o_cursor_col <= r_cur_col;
            o_cursor_row <= r_cur_row[4:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left    <= 7'd0;
            r_top     <= 5'd0;
            r_right   <= 7'd79;
            r_bottom  <= 5'd24;
            r_cur_col <= 7'd0;
            r_cur_row <= 6'd0;
        end else begin
            r_left   <= n_left;
            r_top    <= n_top;
            r_right  <= n_right;
            r_bottom <= n_bottom;
            if (i_cfg_we) begin
                r_cur_col <= el;
                r_cur_row <= {1'b0, et};
            end else begin
                case (i_cmd.cu)
                    CU_HOME: begin
                        r_cur_col <= el;
                        r_cur_row <= {1'b0, et};
                    end
                    CU_ROWB: begin
                        r_cur_row <= {1'b0, eb};
                    end
                    CU_NL: begin
                        r_cur_col <= el;
                        r_cur_row <= r_cur_row + 6'd1;
                    end
                    CU_CR: begin
                        r_cur_col <= el;
                    end
                    CU_ADV: begin
                        if (r_cur_col == er) begin
                            r_cur_col <= el;
                            r_cur_row <= r_cur_row + 6'd1;
                        end else begin
                            r_cur_col <= r_cur_col + 7'd1;
                        end
                    end
                    CU_MOVE: begin
                        r_cur_col <= (mv_col > 9'(er)) ? er : mv_col[6:0];
                        r_cur_row <= (mv_row > 9'(eb)) ? {1'b0, eb} : {1'b0, mv_row[4:0]};
                    end
                    default: begin
                        r_cur_col <= r_cur_col;
                    end
                endcase
            end
        end
    end

endmodule

// ===== rtl/text_console_scroll_engine_unit.sv =====
// Clears and newline erases write spaces one cell at a time; a partial scroll reads and then
// writes each moved cell and afterwards blanks the freed rows one cell at a time, all through
// the single screen memory port pair. One item is in work at a time; the next is taken once
// the result sits in the output register.
// Reset is synchronous; afterwards a clearing pass writes spaces to all COLS*ROWS cells
// before the first input transfer is taken.
module text_console_scroll_engine_unit
    import tcse_pkg::*;
#(
    parameter int COLS = DEF_COLS,
    parameter int ROWS = DEF_ROWS
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_index,
    input  logic [6:0] i_cfg_data,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [2:0] i_mode,
    input  logic [7:0] i_char_code,
    input  logic [7:0] i_col,
    input  logic [7:0] i_row,
    input  logic [7:0] i_scroll_lines,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_cell_char,
    output logic [6:0] o_cursor_col,
    output logic [4:0] o_cursor_row
);

    t_cmd  cmd;
    t_stat stat;

    tcse_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    tcse_dp #(
        .COLS (COLS),
        .ROWS (ROWS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_mode         (i_mode),
        .i_char_code    (i_char_code),
        .i_col          (i_col),
        .i_row          (i_row),
        .i_scroll_lines (i_scroll_lines),
        .o_cell_char    (o_cell_char),
        .o_cursor_col   (o_cursor_col),
        .o_cursor_row   (o_cursor_row),
        .i_cmd          (cmd),
        .o_stat         (stat)
    );

endmodule

// ===== tb/tb_text_console_scroll_engine_unit.sv =====
`timescale 1ns / 100ps

module tb_text_console_scroll_engine_unit;
    import tcse_pkg::*;

    localparam int NCOLS = DEF_COLS;
    localparam int NROWS = DEF_ROWS;

    typedef struct packed {
        logic [7:0] cell_char;
        logic [6:0] cursor_col;
        logic [4:0] cursor_row;
    } t_cursor_report;

    class console_scoreboard;
        logic [7:0] screen [NCOLS*NROWS];
        int cur_col, cur_row;
        int reg_left, reg_top, reg_right, reg_bottom;
        t_cursor_report reports_due[$];
        int errors;

        function new();
            foreach (screen[i]) screen[i] = CH_SP;
            cur_col = 0;
            cur_row = 0;
            reg_left = 0;
            reg_top = 0;
            reg_right = 79;
            reg_bottom = 24;
            errors = 0;
        endfunction

        function int clip(int lo, int v, int hi);
            if (v < lo) v = lo;
            if (v > hi) v = hi;
            return v;
        endfunction

        function int l_edge();
            return clip(0, reg_left, NCOLS - 1);
        endfunction
        function int t_edge();
            return clip(0, reg_top, NROWS - 1);
        endfunction
        function int r_edge();
            return clip(l_edge(), reg_right, NCOLS - 1);
        endfunction
        function int b_edge();
            return clip(t_edge(), reg_bottom, NROWS - 1);
        endfunction

        function void poke(int x, int y, logic [7:0] c);
            if (x < NCOLS && y < NROWS) screen[y*NCOLS + x] = c;
        endfunction

        function void blank_region();
            for (int y = t_edge(); y <= b_edge(); y++)
                for (int x = l_edge(); x <= r_edge(); x++) poke(x, y, CH_SP);
        endfunction

        function void roll_up(int n);
            int l, r, t, b, y;
            l = l_edge(); r = r_edge(); t = t_edge(); b = b_edge();
            if (n > b - t) begin
                blank_region();
                cur_col = l;
                cur_row = t;
                return;
            end
            for (y = t; y + n <= b; y++)
                for (int x = l; x <= r; x++) poke(x, y, screen[(y+n)*NCOLS + x]);
            for (; y <= b; y++)
                for (int x = l; x <= r; x++) poke(x, y, CH_SP);
        endfunction

        function void write_reg(logic [1:0] idx, logic [6:0] val);
            case (idx)
                REG_LEFT:   reg_left = val;
                REG_TOP:    reg_top = val[4:0];
                REG_RIGHT:  reg_right = val;
                REG_BOTTOM: reg_bottom = val[4:0];
                default:    reg_left = reg_left;
            endcase
            cur_col = l_edge();
            cur_row = t_edge();
        endfunction

        function void note(logic [2:0] mode, logic [7:0] ch, int col, int row, int lines);
            int l, r, limit;
            t_cursor_report rep;
            rep.cell_char = 8'd0;
            l = l_edge(); r = r_edge();
            case (mode)
                MD_PUT_CUR: begin
                    if (cur_row > b_edge()) begin
                        roll_up(cur_row - b_edge());
                        cur_row = b_edge();
                    end
                    if (ch == CH_NL) begin
                        while (cur_col <= r) begin
                            poke(cur_col, cur_row, CH_SP);
                            cur_col++;
                        end
                        cur_col = l;
                        cur_row++;
                    end else if (ch == CH_CR) begin
                        cur_col = l;
                    end else begin
                        poke(cur_col, cur_row, ch);
                        cur_col++;
                        if (cur_col > r) begin
                            cur_col = l;
                            cur_row++;
                        end
                    end
                end
                MD_PUT_CELL: begin
                    if (ch == CH_NL) begin
                        if (col > r) limit = NCOLS - 1;
                        else if (col >= l) limit = r;
                        else limit = l - 1;
                        for (int x = col; x <= limit; x++) poke(x, row, CH_SP);
                    end else begin
                        poke(col, row, ch);
                    end
                end
                MD_MOVE: begin
                    cur_col = clip(l, col + l, r);
                    cur_row = clip(t_edge(), row + t_edge(), b_edge());
                end
                MD_CLR_REG: blank_region();
                MD_CLR_SCR: foreach (screen[i]) screen[i] = CH_SP;
                MD_SCROLL:  roll_up(lines);
                MD_READ: begin
                    if (col < NCOLS && row < NROWS) rep.cell_char = screen[row*NCOLS + col];
                end
                default: ;
            endcase
            rep.cursor_col = 7'(cur_col);
            rep.cursor_row = 5'(cur_row);
            reports_due.push_back(rep);
        endfunction

        function void check(t_cursor_report got);
            t_cursor_report exp;
            if (reports_due.size() == 0) begin
                $display("%0t: unexpected result char %0d col %0d row %0d", $time,
                         got.cell_char, got.cursor_col, got.cursor_row);
                errors++;
                return;
            end
            exp = reports_due.pop_front();
            if (got.cell_char !== exp.cell_char) begin
                $display("%0t: cell_char expected %0d actual %0d", $time,
                         exp.cell_char, got.cell_char);
                errors++;
            end
            if (got.cursor_col !== exp.cursor_col) begin
                $display("%0t: cursor_col expected %0d actual %0d", $time,
                         exp.cursor_col, got.cursor_col);
                errors++;
            end
            if (got.cursor_row !== exp.cursor_row) begin
                $display("%0t: cursor_row expected %0d actual %0d", $time,
                         exp.cursor_row, got.cursor_row);
                errors++;
            end
        endfunction
    endclass

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_cfg_we = 1'b0;
    logic [1:0] i_cfg_index = '0;
    logic [6:0] i_cfg_data = '0;
    logic       i_in_valid = 1'b0;
    logic       o_in_ready;
    logic [2:0] i_mode = '0;
    logic [7:0] i_char_code = '0;
    logic [7:0] i_col = '0;
    logic [7:0] i_row = '0;
    logic [7:0] i_scroll_lines = '0;
    logic       o_out_valid;
    logic       i_out_ready = 1'b0;
    logic [7:0] o_cell_char;
    logic [6:0] o_cursor_col;
    logic [4:0] o_cursor_row;

    int sender_idle_pct = 0;
    int receiver_idle_pct = 0;
    console_scoreboard console_sb = new();

    text_console_scroll_engine_unit DUT (.*);

    always #4 i_clk = ~i_clk;

    always @(negedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= receiver_idle_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            console_sb.check({o_cell_char, o_cursor_col, o_cursor_row});
        end
    end

    initial begin
        #200_000_000;
        $display("text_console_scroll_engine_unit: mismatch");
        $finish;
    end

    task automatic send_item(logic [2:0] mode, logic [7:0] ch, logic [7:0] col,
                             logic [7:0] row, logic [7:0] lines);
        while ($urandom_range(99) < sender_idle_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_mode = mode;
        i_char_code = ch;
        i_col = col;
        i_row = row;
        i_scroll_lines = lines;
        i_in_valid = 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        console_sb.note(mode, ch, col, row, lines);
        @(negedge i_clk);
    endtask

    task automatic drain();
        i_in_valid = 1'b0;
        while (console_sb.reports_due.size() != 0) @(negedge i_clk);
        repeat (10) @(negedge i_clk);
    endtask

    task automatic write_region(logic [6:0] left, logic [6:0] top,
                                logic [6:0] right, logic [6:0] bottom);
        logic [6:0] vals [4];
        vals = '{left, top, right, bottom};
        drain();
        for (int k = 0; k < 4; k++) begin
            i_cfg_we = 1'b1;
            i_cfg_index = 2'(k);
            i_cfg_data = vals[k];
            @(negedge i_clk);
            console_sb.write_reg(2'(k), vals[k]);
        end
        i_cfg_we = 1'b0;
    endtask

    task automatic random_item();
        int pick;
        logic [7:0] ch, col, row, lines;
        pick = $urandom_range(99);
        ch = 8'($urandom_range(255));
        col = ($urandom_range(9) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(79));
        row = ($urandom_range(9) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(24));
        lines = ($urandom_range(7) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(4));
        if (pick < 42) begin
            if ($urandom_range(9) == 0) ch = CH_NL;
            else if ($urandom_range(19) == 0) ch = CH_CR;
            send_item(MD_PUT_CUR, ch, col, row, lines);
        end else if (pick < 58) begin
            if ($urandom_range(5) == 0) ch = CH_NL;
            send_item(MD_PUT_CELL, ch, col, row, lines);
        end else if (pick < 68) begin
            send_item(MD_MOVE, ch, col, row, lines);
        end else if (pick < 86) begin
            send_item(MD_READ, ch, col, row, lines);
        end else if (pick < 89) begin
            send_item(MD_CLR_REG, ch, col, row, lines);
        end else if (pick < 91) begin
            send_item(MD_CLR_SCR, ch, col, row, lines);
        end else if (pick < 98) begin
            send_item(MD_SCROLL, ch, col, row, lines);
        end else begin
            send_item(MD_UNUSED, ch, col, row, lines);
        end
    endtask

    initial begin
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;

        send_item(MD_READ, 8'd0, 8'd0, 8'd0, 8'd0);
        send_item(MD_PUT_CUR, 8'hFF, 8'd0, 8'd0, 8'd0);
        send_item(MD_PUT_CUR, CH_NL, 8'd0, 8'd0, 8'd0);
        send_item(MD_PUT_CUR, 8'h00, 8'd0, 8'd0, 8'd0);
        send_item(MD_PUT_CUR, CH_CR, 8'd0, 8'd0, 8'd0);
        send_item(MD_PUT_CELL, 8'h41, 8'd79, 8'd24, 8'd0);
        send_item(MD_READ, 8'd0, 8'd79, 8'd24, 8'd0);
        send_item(MD_PUT_CELL, 8'h42, 8'd80, 8'd0, 8'd0);
        send_item(MD_PUT_CELL, 8'h43, 8'd255, 8'd255, 8'd0);
        send_item(MD_READ, 8'd0, 8'd0, 8'd25, 8'd0);
        send_item(MD_MOVE, 8'd0, 8'd255, 8'd255, 8'd0);
        send_item(MD_PUT_CUR, 8'h5A, 8'd0, 8'd0, 8'd0);
        send_item(MD_PUT_CUR, 8'h59, 8'd0, 8'd0, 8'd0);
        send_item(MD_SCROLL, 8'd0, 8'd0, 8'd0, 8'd0);
        send_item(MD_SCROLL, 8'd0, 8'd0, 8'd0, 8'd1);
        send_item(MD_UNUSED, 8'd0, 8'd0, 8'd0, 8'd0);
        write_region(7'd10, 7'd5, 7'd20, 7'd8);
        send_item(MD_PUT_CELL, CH_NL, 8'd3, 8'd6, 8'd0);
        send_item(MD_PUT_CELL, CH_NL, 8'd30, 8'd6, 8'd0);
        send_item(MD_PUT_CELL, CH_NL, 8'd15, 8'd6, 8'd0);
        send_item(MD_MOVE, 8'd0, 8'd0, 8'd0, 8'd0);
        send_item(MD_CLR_REG, 8'd0, 8'd0, 8'd0, 8'd0);
        send_item(MD_SCROLL, 8'd0, 8'd0, 8'd0, 8'd255);
        send_item(MD_CLR_SCR, 8'd0, 8'd0, 8'd0, 8'd0);

        sender_idle_pct = 21;
        receiver_idle_pct = 70;
        write_region(7'd0, 7'd0, 7'd127, 7'd127);
        for (int n = 0; n < 550; n++) begin
            if (n == 275) drain();
            random_item();
        end

        sender_idle_pct = 70;
        receiver_idle_pct = 21;
        write_region(7'd127, 7'd127, 7'd0, 7'd0);
        for (int n = 0; n < 150; n++) random_item();
        write_region(7'($urandom_range(127)), 7'($urandom_range(31)),
                     7'($urandom_range(127)), 7'($urandom_range(31)));
        for (int n = 0; n < 400; n++) random_item();

        sender_idle_pct = 0;
        receiver_idle_pct = 0;
        write_region(7'($urandom_range(40)), 7'($urandom_range(12)),
                     7'($urandom_range(40, 127)), 7'($urandom_range(12, 31)));
        for (int n = 0; n < 550; n++) random_item();

        drain();
        repeat (50) @(posedge i_clk);
        if (console_sb.errors == 0 && console_sb.reports_due.size() == 0) begin
            $display("text_console_scroll_engine_unit: match");
        end else begin
            $display("text_console_scroll_engine_unit: mismatch");
        end
        $finish;
    end

endmodule
